### rtl/kwm_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// kwm_pkg
// Shared types, constants and helper functions of the keyword matcher.
// ============================================================================
package kwm_pkg;

    // Number of keyword cells and bytes per keyword.
    localparam int PATTERNS   = 4;
    localparam int MAX_LEN    = 8;

    // Widths fixed by the register map and the result fields.
    localparam int PAT_W       = 64;
    localparam int CHAR_W      = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int COUNT_W     = 3;
    localparam int FOUND_IDX_W = 2;

    // Widths derived from the array size.
    localparam int POS_W  = $clog2(MAX_LEN + 1);
    localparam int IDX_W  = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;
    localparam int NUM_W  = $clog2(PATTERNS + 1) > COUNT_W + 1 ?
                            $clog2(PATTERNS + 1) : COUNT_W + 1;

    // Only the first four registers of the map hold keywords.
    localparam int PATTERN_REGS = 4;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UP_Z  = 8'h5A;

    localparam logic REQ_CONSUME = 1'b0;
    localparam logic REQ_RESTART = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_0     = 3'd0,
        CFG_PATTERN_1     = 3'd1,
        CFG_PATTERN_2     = 3'd2,
        CFG_PATTERN_3     = 3'd3,
        CFG_PATTERN_COUNT = 3'd4,
        CFG_SKIP_SPACES   = 3'd5,
        CFG_MATCH_MODE    = 3'd6
    } cfg_addr_t;

    typedef enum logic {
        MODE_PREFIX = 1'b0,
        MODE_SIMPLE = 1'b1
    } mode_t;

    // One character transaction as it travels down the row of cells, with
    // the partial result gathered so far.
    typedef struct packed {
        logic              restart;
        logic [CHAR_W-1:0] chr;
        logic              first;
        logic              start;
        logic              active;
        logic              found;
        logic [IDX_W-1:0]  idx;
    } item_t;

    // Byte at a keyword position; positions past the keyword storage read zero.
    function automatic logic [CHAR_W-1:0] kw_byte(
        input logic [PAT_W-1:0] pat,
        input logic [POS_W-1:0] pos
    );
        logic [CHAR_W-1:0] b;
        b = CHAR_NUL;
        for (int k = 0; k < MAX_LEN; k++) begin
            if (pos == POS_W'(k))
            begin
                b = pat[CHAR_W*k +: CHAR_W];
            end
        end
        return b;
    endfunction

endpackage

### rtl/kwm_cell.sv
`timescale 1ns / 1ps
// ============================================================================
// kwm_cell
// One keyword cell: holds a keyword and its match position, updates the
// position for each passing transaction and forwards it to the next cell.
// ============================================================================
module kwm_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic [kwm_pkg::IDX_W-1:0]   cell_idx,
    input  logic                        in_use,
    input  kwm_pkg::mode_t              mode,
    input  logic                        pat_write,
    input  logic [kwm_pkg::PAT_W-1:0]   pat_data,
    input  logic                        vld_i,
    input  kwm_pkg::item_t              item_i,
    output logic                        vld_o,
    output kwm_pkg::item_t              item_o
);
    import kwm_pkg::*;

    logic [PAT_W-1:0]  pattern_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic              vld_reg;
    item_t             item_reg;
    item_t             item_next;

    logic [CHAR_W-1:0] byte_cur;
    logic [CHAR_W-1:0] byte_first;
    logic [CHAR_W-1:0] byte_new;
    logic              hit;
    logic              live;
    logic              adv_hit;
    logic [POS_W-1:0]  pos_inc;

    assign byte_cur   = kw_byte(pattern_reg, pos_reg);
    assign byte_first = pattern_reg[CHAR_W-1:0];
    assign hit        = (byte_cur == item_i.chr);
    assign live       = in_use && (item_i.chr != CHAR_NUL);
    assign pos_inc    = pos_reg + POS_W'(1);

    always_comb
    begin
        pos_next = pos_reg;
        adv_hit  = 1'b0;
        if (item_i.restart)
        begin
            pos_next = '0;
        end
        else if (live)
        begin
            if (mode == MODE_PREFIX)
            begin
                if (item_i.first)
                begin
                    if (item_i.start && (byte_first == item_i.chr))
                    begin
                        pos_next = POS_W'(1);
                    end
                end
                else if (pos_reg != '0)
                begin
                    adv_hit  = hit;
                    pos_next = hit ? pos_inc : '0;
                end
            end
            else
            begin
                if (hit)
                begin
                    pos_next = pos_inc;
                end
                else if (byte_first == item_i.chr)
                begin
                    pos_next = POS_W'(1);
                end
                else
                begin
                    pos_next = '0;
                end
            end
        end
    end

    assign byte_new = kw_byte(pattern_reg, pos_next);

    always_comb
    begin
        item_next = item_i;
        if (!item_i.restart && in_use)
        begin
            if (mode == MODE_PREFIX)
            begin
                item_next.active = item_i.active | adv_hit;
            end
            else
            begin
                item_next.active = item_i.active | (pos_next != '0);
            end
            // The lowest-index hit wins, so an earlier cell's find is kept.
            if (!item_i.found && (pos_next != '0) && (byte_new == CHAR_NUL))
            begin
                item_next.found = 1'b1;
                item_next.idx   = cell_idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
        end
        else if (pat_write)
        begin
            pattern_reg <= pat_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= vld_i;
            if (vld_i)
            begin
                pos_reg <= pos_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg <= item_next;
        end
    end

    assign vld_o  = vld_reg;
    assign item_o = item_reg;

endmodule

### rtl/multi_keyword_char_matcher_core.sv
`timescale 1ns / 1ps
// A character passes through the register of every keyword cell in turn; the last cell's
// register drives result_valid, and the result is taken while result_ready is high.
// Throughput: one character per cycle; the row of cells advances as one pipeline and
// stalls only while the result in the last cell is not taken.
// Reset: keywords clear to zero, pattern_count to 0, skip_leading_spaces to 1,
// match_mode to prefix; all match positions clear and the matcher awaits a first character.
// ============================================================================
// multi_keyword_char_matcher_core
// Multi-keyword character matcher built as a row of keyword cells.
// ============================================================================
module multi_keyword_char_matcher_core (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write port.
    input  logic                               cfg_write,
    input  logic [kwm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [kwm_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Character channel.
    input  logic                               item_valid,
    output logic                               item_ready,
    input  logic                               req_type,
    input  logic [kwm_pkg::CHAR_W-1:0]         char_in,
    // Result channel.
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic                               active,
    output logic                               found,
    output logic [kwm_pkg::FOUND_IDX_W-1:0]    found_index
);
    import kwm_pkg::*;

    // Global configuration. Keyword registers live inside their cells.
    logic [COUNT_W-1:0] count_reg;
    logic               skip_reg;
    mode_t              mode_reg;

    // Set after reset or a restart; cleared by the first character that
    // starts matching in prefix mode.
    logic               awaiting_first_reg;
    logic               awaiting_first_next;

    // The row advances as a whole whenever the last cell can hand its
    // transaction on, so an item can enter every cycle.
    logic               adv;
    logic               accept;

    logic [PATTERNS:0]  vld_chain;
    item_t              item_chain [PATTERNS+1];

    logic [CHAR_W-1:0]  chr_lc;
    logic               start_ok;
    logic               is_restart;

    assign adv        = !vld_chain[PATTERNS] || result_ready;
    assign item_ready = adv;
    assign accept     = item_valid && item_ready;

    // ------------------------------------------------------------------------
    // Configuration registers. The user must write these only while the block is idle; the block
    // itself does not enforce it, so the cells may read these directly.
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            skip_reg  <= 1'b1;
            mode_reg  <= MODE_PREFIX;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_PATTERN_COUNT: count_reg <= cfg_data[COUNT_W-1:0];
                CFG_SKIP_SPACES:   skip_reg  <= cfg_data[0];
                CFG_MATCH_MODE:    mode_reg  <= mode_t'(cfg_data[0]);
                default:
                begin
                    // Keyword indexes are decoded per cell; others are ignored.
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Front end: lowercase in prefix mode, decide whether this character is
    // the first one and whether it may start keywords, then launch it into
    // the first cell.
    // ------------------------------------------------------------------------
    assign is_restart = (req_type == REQ_RESTART);

    always_comb
    begin
        chr_lc = char_in;
        if ((mode_reg == MODE_PREFIX) && (char_in >= CHAR_UP_A) && (char_in <= CHAR_UP_Z))
        begin
            chr_lc = char_in | CHAR_SPACE;
        end
    end

    // A leading space is swallowed only when skipping is enabled.
    assign start_ok = !skip_reg || (chr_lc != CHAR_SPACE);

    always_comb
    begin
        item_chain[0].restart = is_restart;
        item_chain[0].chr     = chr_lc;
        item_chain[0].first   = (mode_reg == MODE_PREFIX) && awaiting_first_reg;
        item_chain[0].start   = start_ok;
        // In prefix mode the first non-zero character always reports active,
        // whether or not any keyword starts on it.
        item_chain[0].active  = !is_restart && (mode_reg == MODE_PREFIX) &&
                                awaiting_first_reg && (chr_lc != CHAR_NUL);
        item_chain[0].found   = 1'b0;
        item_chain[0].idx     = '0;
    end

    assign vld_chain[0] = item_valid;

    always_comb
    begin
        awaiting_first_next = awaiting_first_reg;
        if (accept)
        begin
            if (is_restart)
            begin
                awaiting_first_next = 1'b1;
            end
            else if ((mode_reg == MODE_PREFIX) && awaiting_first_reg &&
                     (chr_lc != CHAR_NUL) && start_ok)
            begin
                awaiting_first_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_first_reg <= 1'b1;
        end
        else
        begin
            awaiting_first_reg <= awaiting_first_next;
        end
    end

    // ------------------------------------------------------------------------
    // Row of keyword cells. Each cell owns one keyword and its position; the
    // transaction and its partial result move one cell per cycle while the row advances.
    // ------------------------------------------------------------------------
    for (genvar u = 0; u < PATTERNS; u++)
    begin : g_cell
        logic in_use;
        logic pat_write;

        assign in_use = ({1'b0, count_reg} > NUM_W'(u));

        if (u < PATTERN_REGS)
        begin : g_wr
            assign pat_write = cfg_write &&
                               (cfg_index == CFG_IDX_W'(int'(CFG_PATTERN_0) + u));
        end
        else
        begin : g_nowr
            assign pat_write = 1'b0;
        end

        kwm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .cell_idx  (IDX_W'(u)),
            .in_use    (in_use),
            .mode      (mode_reg),
            .pat_write (pat_write),
            .pat_data  (cfg_data[PAT_W-1:0]),
            .vld_i     (vld_chain[u]),
            .item_i    (item_chain[u]),
            .vld_o     (vld_chain[u+1]),
            .item_o    (item_chain[u+1])
        );
    end

    // The last cell's register is the output register.
    assign result_valid = vld_chain[PATTERNS];
    assign active       = item_chain[PATTERNS].active;
    assign found        = item_chain[PATTERNS].found;
    assign found_index  = FOUND_IDX_W'(item_chain[PATTERNS].idx);

`ifndef SYNTHESIS
    // A reported index without a find would mean a cell overwrote the index
    // of an empty result.
    a_index_needs_found: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid && !found |-> (found_index == '0)
    ) else $error("found_index nonzero without found");

    // A printable first character in prefix mode must end the wait for the
    // first character.
    a_first_clears: assert property (
        @(posedge clk) disable iff (!rst_n)
        accept && (req_type == REQ_CONSUME) && (mode_reg == MODE_PREFIX) &&
        (char_in != CHAR_NUL) && (char_in != CHAR_SPACE)
        |=> !awaiting_first_reg
    ) else $error("awaiting_first not cleared by first character");

    // While the row is stalled no transaction may appear or vanish in it.
    a_stall_holds_row: assert property (
        @(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_chain[PATTERNS:1])
    ) else $error("cell row changed during a stall");

    // A restart always delivers an empty result at the same position in the
    // stream, so the row must not drop a transaction while it advances.
    a_advance_shifts: assert property (
        @(posedge clk) disable iff (!rst_n)
        adv |=> (vld_chain[1] == $past(item_valid))
    ) else $error("first cell did not capture the incoming transaction");
`endif

endmodule
